>>> rtl/mts_pkg.sv
// -----------------------------------------------------------------------------
// mts_pkg: shared types and codes for the minimum tracking stack.
// Holds the request and result word layouts and the opcode and status codes.
// -----------------------------------------------------------------------------
package mts_pkg;

	// Opcodes of a request word. The unused code behaves as a query.
	localparam logic [1:0] OP_QUERY = 2'd0;
	localparam logic [1:0] OP_PUSH  = 2'd1;
	localparam logic [1:0] OP_POP   = 2'd2;

	// Status codes of a result word.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 11;

	// Request word.
	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [DATA_W-1:0] push_value;
	} mts_req_t;

	// Result word.
	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] min_value;
		logic [COUNT_W-1:0]       entry_count;
		logic                     is_empty;
		logic [1:0]               status;
	} mts_rsp_t;

endpackage

>>> rtl/mts_ram.sv
// -----------------------------------------------------------------------------
// mts_ram: generic single-port-write, single-port-read synchronous RAM.
// One write and one read per cycle; read data is registered.
// -----------------------------------------------------------------------------
module mts_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/min_tracking_stack.sv
// -----------------------------------------------------------------------------
// min_tracking_stack: LIFO stack of signed 32-bit values with running minimum.
// Each request is a push, a pop or a query; each gives one result word.
// -----------------------------------------------------------------------------
// Usage:
// A request word on req is taken at a rising edge where start is high and
// busy is low. Every request gives exactly one result word on rsp, valid for
// the single cycle in which done is high; the receiver cannot stall.
// The result describes the stack after the operation: top value, current
// minimum (both zero when empty), entry count, empty flag and status.
// A push to a full stack or a pop from an empty stack is refused with a
// status code and leaves the stack unchanged.
// Flow: push, query and refused or emptying pops return in the cycle after
// acceptance, and busy stays low, so these run one per cycle. A pop that
// leaves entries behind must fetch the new top from the entry RAM, whose
// read is registered: busy is high for one cycle, in the wait state, and
// the result word is registered from the RAM read data in that state.
// The top entry and its minimum live in registers; all pushed entries also
// sit in one RAM of STACK_DEPTH words. Reset empties the stack at once; the
// RAM needs no clearing since only entries below the count are ever used.
// -----------------------------------------------------------------------------
module min_tracking_stack
	import mts_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  mts_req_t req,
	output logic     done,
	output mts_rsp_t rsp
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned EW = 2 * DATA_W;

	typedef enum logic {
		S_IDLE,
		S_POP_WAIT
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] min_q;
	logic                     done_q;
	mts_rsp_t                 rsp_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic [CW-1:0]            count_inc;
	logic [CW-1:0]            count_dec;
	logic [CW-1:0]            below_idx;
	logic signed [DATA_W-1:0] new_min;
	logic                     ram_we;
	logic [EW-1:0]            ram_wdata;
	logic [EW-1:0]            ram_rdata;

	// Handshake and occupancy decode.
	assign accept    = start && (state_q == S_IDLE);
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign empty     = (count_q == '0);
	assign count_inc = count_q + CW'(1);
	assign count_dec = count_q - CW'(1);
	assign below_idx = count_q - CW'(2);

	// Running minimum for a push: ties keep the minimum already held.
	always_comb begin
		new_min = req.push_value;
		if (!empty && !(req.push_value < min_q)) begin
			new_min = min_q;
		end
	end

	// Every accepted push to a non-full stack is written at the current count.
	assign ram_we    = accept && (req.opcode == OP_PUSH) && !full;
	assign ram_wdata = {req.push_value, new_min};

	mts_ram #(
		.WIDTH(EW),
		.DEPTH(STACK_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(ram_wdata),
		.raddr(below_idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Control state, cached top entry and registered result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			top_q   <= '0;
			min_q   <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						done_q            <= 1'b1;
						rsp_q.status      <= ST_OK;
						rsp_q.top_value   <= top_q;
						rsp_q.min_value   <= min_q;
						rsp_q.entry_count <= COUNT_W'(count_q);
						rsp_q.is_empty    <= empty;
						if (req.opcode == OP_PUSH) begin
							if (full) begin
								rsp_q.status <= ST_FULL;
							end else begin
								count_q           <= count_inc;
								top_q             <= req.push_value;
								min_q             <= new_min;
								rsp_q.top_value   <= req.push_value;
								rsp_q.min_value   <= new_min;
								rsp_q.entry_count <= COUNT_W'(count_inc);
								rsp_q.is_empty    <= 1'b0;
							end
						end else if (req.opcode == OP_POP) begin
							if (empty) begin
								rsp_q.status <= ST_EMPTY;
							end else if (count_dec == '0) begin
								count_q           <= count_dec;
								top_q             <= '0;
								min_q             <= '0;
								rsp_q.top_value   <= '0;
								rsp_q.min_value   <= '0;
								rsp_q.entry_count <= '0;
								rsp_q.is_empty    <= 1'b1;
							end else begin
								// New top comes from the RAM next cycle.
								count_q <= count_dec;
								done_q  <= 1'b0;
								state_q <= S_POP_WAIT;
							end
						end
					end
				end
				S_POP_WAIT: begin
					top_q             <= $signed(ram_rdata[EW-1:DATA_W]);
					min_q             <= $signed(ram_rdata[DATA_W-1:0]);
					done_q            <= 1'b1;
					rsp_q.status      <= ST_OK;
					rsp_q.top_value   <= $signed(ram_rdata[EW-1:DATA_W]);
					rsp_q.min_value   <= $signed(ram_rdata[DATA_W-1:0]);
					rsp_q.entry_count <= COUNT_W'(count_q);
					rsp_q.is_empty    <= 1'b0;
					state_q           <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == S_POP_WAIT);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	// The count never runs past the depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count exceeds depth");

	// The wait state only follows an accepted pop.
	a_wait_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(accept && (req.opcode == OP_POP)))
		else $error("pop wait entered without a pop");

	// A pop wait always ends with a result on the next cycle.
	a_wait_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("pop wait did not deliver a result");

	// No result is shown while the block waits on the RAM.
	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe during pop wait");

	// The empty flag agrees with the reported count.
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.is_empty == (rsp.entry_count == '0)))
		else $error("empty flag disagrees with count");
`endif

endmodule

>>> tb/sv/tb_min_tracking_stack.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_min_tracking_stack: self-checking bench for the minimum tracking stack.
// A queue of request words feeds a clocked driver. At each accepted word the
// bench's own stack model predicts the result word. A clocked monitor compares
// every result word field by field with the oldest prediction. The stimulus
// has a directed opening, random bursts of pushes, pops and queries, and a
// closing run of pops to drain the stack. Sender gaps vary by phase.
// -----------------------------------------------------------------------------
module tb_min_tracking_stack;
	import mts_pkg::*;

	localparam int unsigned DEPTH     = 1024;
	localparam int unsigned MAX_GAP   = 40;
	localparam int unsigned STALL_LIM = 4000;
	localparam int unsigned RAND_OPS  = 580;

	// Unused opcode, which the block treats as a query.
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	mts_req_t req = '0;
	logic     done;
	mts_rsp_t rsp;

	min_tracking_stack #(
		.STACK_DEPTH(DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	// Request words waiting to be sent, each with the idle cycles before it.
	mts_req_t    pending_reqs[$];
	int unsigned pending_gaps[$];
	mts_rsp_t    due_results[$];
	mts_rsp_t    oldest_result;
	int unsigned idle_pct = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;

	// Stack model: values, running minima and the entry count.
	logic signed [DATA_W-1:0] model_values[DEPTH];
	logic signed [DATA_W-1:0] model_minima[DEPTH];
	int unsigned              model_fill = 0;

	// Free-running clock with an 8 ns period.
	initial begin
		forever #4 clk = ~clk;
	end

	// Apply one request word to the stack model and return the result word.
	function automatic mts_rsp_t apply_stack_op(input mts_req_t w);
		mts_rsp_t                 r;
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] m;
		r = '0;
		v = w.push_value;
		r.status = ST_OK;
		case (w.opcode)
			OP_PUSH: begin
				if (model_fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// An equal value keeps the minimum already held.
					m = v;
					if (model_fill > 0 && !(v < model_minima[model_fill-1]))
						m = model_minima[model_fill-1];
					model_values[model_fill] = v;
					model_minima[model_fill] = m;
					model_fill++;
				end
			end
			OP_POP: begin
				if (model_fill == 0)
					r.status = ST_EMPTY;
				else
					model_fill--;
			end
			default: begin
				// Query, and the unused code that acts as one.
			end
		endcase
		if (model_fill > 0) begin
			r.top_value = model_values[model_fill-1];
			r.min_value = model_minima[model_fill-1];
		end
		r.entry_count = model_fill[COUNT_W-1:0];
		r.is_empty    = (model_fill == 0);
		return r;
	endfunction

	// Queue one request word with a random gap drawn from the current idle rate.
	task automatic queue_op(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
		mts_req_t    w;
		int unsigned gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		w.opcode     = op;
		w.push_value = v;
		pending_reqs.push_back(w);
		pending_gaps.push_back(gap);
	endtask

	// Values lean toward the extremes and a narrow band that repeats often.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3, 4: return $signed($urandom_range(16)) - 8;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic logic [1:0] pick_op(input bit grow);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 6)
			return OP_SPARE;
		else if (roll < 20)
			return OP_QUERY;
		else if (roll < (grow ? 75 : 40))
			return OP_PUSH;
		else
			return OP_POP;
	endfunction

	task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
		input logic signed [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Driver: hold a word while busy, otherwise send the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy) begin
				due_results.push_back(apply_stack_op(req));
				void'(pending_reqs.pop_front());
				void'(pending_gaps.pop_front());
			end
			if (start && busy) begin
				// The word stays on the port until it is taken.
			end else if (pending_reqs.size() == 0) begin
				start <= 1'b0;
			end else if (pending_gaps[0] > 0) begin
				pending_gaps[0] = pending_gaps[0] - 1;
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				req   <= pending_reqs[0];
			end
		end
	end

	// Monitor: every result word must match the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				$error("result word with no prediction waiting");
				fail_count++;
			end else begin
				oldest_result = due_results.pop_front();
				check_field("top_value", oldest_result.top_value, rsp.top_value);
				check_field("min_value", oldest_result.min_value, rsp.min_value);
				check_field("entry_count", DATA_W'(oldest_result.entry_count),
					DATA_W'(rsp.entry_count));
				check_field("is_empty", DATA_W'(oldest_result.is_empty),
					DATA_W'(rsp.is_empty));
				check_field("status", DATA_W'(oldest_result.status),
					DATA_W'(rsp.status));
			end
		end
	end

	// Watchdog: too long without an accepted word or a result ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIM) begin
				$display("tb_min_tracking_stack failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned sent;
		int unsigned burst;
		bit          grow;

		// Directed opening on an empty stack: refused pop, queries, extremes,
		// equal minima, popping back through them and a second refused pop.
		idle_pct = 0;
		queue_op(OP_POP, 32'sd0);
		queue_op(OP_QUERY, 32'sh7FFF_FFFF);
		queue_op(OP_SPARE, -32'sd1);
		queue_op(OP_PUSH, 32'sd0);
		queue_op(OP_PUSH, 32'sh7FFF_FFFF);
		queue_op(OP_PUSH, 32'sh8000_0000);
		queue_op(OP_PUSH, 32'sh8000_0000);
		queue_op(OP_PUSH, -32'sd1);
		queue_op(OP_QUERY, 32'sd0);
		queue_op(OP_SPARE, 32'sh5555_AAAA);
		queue_op(OP_POP, 32'sd0);
		queue_op(OP_POP, 32'sd0);
		queue_op(OP_POP, 32'sd0);
		queue_op(OP_POP, 32'sd0);
		queue_op(OP_POP, 32'sd0);
		queue_op(OP_POP, 32'sd0);
		queue_op(OP_PUSH, 32'sd5);
		queue_op(OP_PUSH, 32'sd5);
		queue_op(OP_PUSH, 32'sd3);
		queue_op(OP_PUSH, 32'sd3);
		queue_op(OP_POP, 32'sd0);
		queue_op(OP_POP, 32'sd0);
		queue_op(OP_POP, 32'sd0);
		queue_op(OP_POP, 32'sd0);

		// Random bursts that each either grow or shrink the stack, over
		// phases with no gaps, heavy gaps, light gaps and no gaps again.
		sent = 0;
		grow = 1'b1;
		while (sent < RAND_OPS) begin
			if (sent < RAND_OPS / 4)
				idle_pct = 0;
			else if (sent < RAND_OPS / 2)
				idle_pct = 82;
			else if (sent < 3 * RAND_OPS / 4)
				idle_pct = 15;
			else
				idle_pct = 0;
			burst = $urandom_range(30, 1);
			repeat (burst) begin
				queue_op(pick_op(grow), pick_value());
				sent++;
			end
			grow = ($urandom_range(99) < 60);
		end

		// Drain with a run of pops, first with heavy gaps, then back to back.
		queue_op(OP_QUERY, 32'sd0);
		idle_pct = 82;
		repeat (10)
			queue_op(OP_POP, 32'sd0);
		idle_pct = 0;
		repeat (30)
			queue_op(OP_POP, pick_value());
		queue_op(OP_QUERY, 32'sd0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && due_results.size() == 0)
			$display("tb_min_tracking_stack passed");
		else
			$display("tb_min_tracking_stack failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/min_tracking_stack.sv
tb/sv/tb_min_tracking_stack.sv
